FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: hdl/sort_pkg.sv
// ----------------------------------------------------------------------------
// sort_pkg
// Types, widths and codes shared by the slot occasion reassembly tracker.
// ----------------------------------------------------------------------------
package sort_pkg;

    // Default sizes
    localparam int DEF_NUM_BUCKETS = 8;
    localparam int DEF_MAX_PORTS   = 16;
    localparam int DEF_MAX_SYMBOLS = 16;

    // Field widths
    localparam int SLOT_W     = 32;
    localparam int SYM_W      = 8;
    localparam int PORT_W     = 8;
    localparam int RES_W      = 3;
    localparam int CNT_OUT_W  = 9;
    localparam int CFG_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [CFG_CNT_W-1:0] RST_NUM_PORTS   = 5'd4;
    localparam logic [CFG_CNT_W-1:0] RST_NUM_SYMBOLS = 5'd12;
    localparam logic [SLOT_W-1:0]    RST_KEEPALIVE   = 32'd4;

    // Item command code
    localparam logic CMD_FLUSH = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_PORTS   = 2'd0,
        REG_NUM_SYMBOLS = 2'd1,
        REG_KEEPALIVE   = 2'd2
    } cfg_reg_t;

    // Result event codes
    typedef enum logic [RES_W-1:0] {
        EV_ACCEPTED     = 3'd0,
        EV_DROP_INVALID = 3'd1,
        EV_DROP_DUP     = 3'd2,
        EV_COMPLETE     = 3'd3,
        EV_EVICT_FULL   = 3'd4,
        EV_EVICT_STALE  = 3'd5,
        EV_FLUSH_DONE   = 3'd6
    } event_t;

    // Which result the datapath builds
    typedef enum logic [2:0] {
        EMIT_INVALID,
        EMIT_EVICT,
        EMIT_STALE,
        EMIT_DONE,
        EMIT_UPDATE
    } emit_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INVALID,
        S_EVICT,
        S_UPDATE,
        S_FLUSH,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;         // item accepted: capture, look up, claim
        logic  emit;         // push a result into the output register
        emit_t kind;
        logic  evict_claim;  // hand bucket 0 to the new slot
        logic  flush_clear;  // free the bucket under the pointer
        logic  ptr_inc;      // next bucket in the flush scan
        logic  commit;       // bitmap and count update
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_flush;
        logic in_invalid;
        logic in_evict;
        logic stale;
        logic ptr_last;
        logic out_space;
    } dp_stat_t;

endpackage

FILE: hdl/sort_ctrl.sv
// ----------------------------------------------------------------------------
// sort_ctrl
// Sequencer for packet and flush items: issues datapath commands and
// holds off while the output register is full.
// ----------------------------------------------------------------------------
module sort_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sort_pkg::dp_stat_t stat,
    output sort_pkg::dp_cmd_t  cmd
);

    sort_pkg::state_t state_reg;
    sort_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sort_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = sort_pkg::EMIT_UPDATE;
        in_ready   = 1'b0;

        case (state_reg)
            sort_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_flush)
                    begin
                        state_next = sort_pkg::S_FLUSH;
                    end
                    else if (stat.in_invalid)
                    begin
                        state_next = sort_pkg::S_INVALID;
                    end
                    else if (stat.in_evict)
                    begin
                        state_next = sort_pkg::S_EVICT;
                    end
                    else
                    begin
                        state_next = sort_pkg::S_UPDATE;
                    end
                end
            end

            sort_pkg::S_INVALID:
            begin
                if (stat.out_space)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sort_pkg::EMIT_INVALID;
                    state_next = sort_pkg::S_IDLE;
                end
            end

            // report bucket 0 before it is handed over
            sort_pkg::S_EVICT:
            begin
                if (stat.out_space)
                begin
                    cmd.emit        = 1'b1;
                    cmd.kind        = sort_pkg::EMIT_EVICT;
                    cmd.evict_claim = 1'b1;
                    state_next      = sort_pkg::S_UPDATE;
                end
            end

            sort_pkg::S_UPDATE:
            begin
                if (stat.out_space)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sort_pkg::EMIT_UPDATE;
                    cmd.commit = 1'b1;
                    state_next = sort_pkg::S_IDLE;
                end
            end

            // one bucket per cycle; a stale one waits for output space
            sort_pkg::S_FLUSH:
            begin
                if (!stat.stale || stat.out_space)
                begin
                    if (stat.stale)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.kind        = sort_pkg::EMIT_STALE;
                        cmd.flush_clear = 1'b1;
                    end
                    if (stat.ptr_last)
                    begin
                        state_next = sort_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end

            sort_pkg::S_DONE:
            begin
                if (stat.out_space)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = sort_pkg::EMIT_DONE;
                    state_next = sort_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sort_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/sort_dp.sv
// ----------------------------------------------------------------------------
// sort_dp
// Bucket table, per-bucket arrival bitmap rows, configuration registers
// and the result register.
// ----------------------------------------------------------------------------
module sort_dp
#(
    parameter int NUM_BUCKETS = sort_pkg::DEF_NUM_BUCKETS,
    parameter int MAX_PORTS   = sort_pkg::DEF_MAX_PORTS,
    parameter int MAX_SYMBOLS = sort_pkg::DEF_MAX_SYMBOLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sort_pkg::dp_cmd_t               cmd,
    output sort_pkg::dp_stat_t              stat,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [sort_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sort_pkg::CFG_DATA_W-1:0] cfg_data,
    // input item
    input  logic                            command,
    input  logic [sort_pkg::SLOT_W-1:0]     slot_id,
    input  logic [sort_pkg::SYM_W-1:0]      symbol_index,
    input  logic [sort_pkg::PORT_W-1:0]     port_index,
    // result item
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [sort_pkg::RES_W-1:0]      event_res,
    output logic [sort_pkg::SLOT_W-1:0]     event_slot,
    output logic [sort_pkg::CNT_OUT_W-1:0]  arrived_count,
    output logic                            last
);

    localparam int MAP_BITS = MAX_PORTS * MAX_SYMBOLS;
    localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int IDX_W    = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
    localparam int CNT_W    = $clog2(MAP_BITS + 1);
    localparam int NP_W     = $clog2(MAX_PORTS + 1);
    localparam int NS_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int TOT_W    = NP_W + NS_W;

    // Configuration
    logic [sort_pkg::CFG_CNT_W-1:0] num_ports_reg;
    logic [sort_pkg::CFG_CNT_W-1:0] num_symbols_reg;
    logic [sort_pkg::SLOT_W-1:0]    keepalive_reg;

    // Current item
    logic [sort_pkg::SLOT_W-1:0] item_slot_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [BKT_W-1:0]            ptr_reg;

    // Bucket table
    logic [NUM_BUCKETS-1:0]      busy_reg;
    logic [NUM_BUCKETS-1:0]      map_valid_reg;
    logic [sort_pkg::SLOT_W-1:0] bkt_slot_reg [NUM_BUCKETS];
    logic [CNT_W-1:0]            bkt_cnt_reg  [NUM_BUCKETS];

    // Bitmap rows, one per bucket
    logic [MAP_BITS-1:0] map_mem [NUM_BUCKETS];
    logic [MAP_BITS-1:0] rd_row_reg;

    // Result register
    logic                           out_valid_reg;
    sort_pkg::event_t               out_res_reg;
    logic [sort_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [sort_pkg::CNT_OUT_W-1:0] out_cnt_reg;
    logic                           out_last_reg;

    logic [NP_W-1:0]             np;
    logic [NS_W-1:0]             ns;
    logic [TOT_W-1:0]            total;
    logic                        in_invalid;
    logic [IDX_W-1:0]            idx_in;
    logic                        match_found;
    logic [BKT_W-1:0]            match_idx;
    logic                        free_found;
    logic [BKT_W-1:0]            free_idx;
    logic [BKT_W-1:0]            sel;
    logic                        is_packet;
    logic                        claim_free;
    logic [CNT_W-1:0]            cur_cnt;
    logic [CNT_W-1:0]            cnt_inc;
    logic [MAP_BITS-1:0]         row_cur;
    logic [MAP_BITS-1:0]         row_wdata;
    logic                        hit;
    logic                        complete;
    logic                        write_bit;
    logic [sort_pkg::SLOT_W-1:0] age;
    logic                        out_space;
    sort_pkg::event_t            emit_res;
    logic [sort_pkg::SLOT_W-1:0] emit_slot;
    logic [CNT_W-1:0]            emit_cnt;
    logic                        emit_last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ports_reg   <= sort_pkg::RST_NUM_PORTS;
            num_symbols_reg <= sort_pkg::RST_NUM_SYMBOLS;
            keepalive_reg   <= sort_pkg::RST_KEEPALIVE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sort_pkg::REG_NUM_PORTS:
                begin
                    num_ports_reg <= cfg_data[sort_pkg::CFG_CNT_W-1:0];
                end
                sort_pkg::REG_NUM_SYMBOLS:
                begin
                    num_symbols_reg <= cfg_data[sort_pkg::CFG_CNT_W-1:0];
                end
                sort_pkg::REG_KEEPALIVE:
                begin
                    keepalive_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective ports and symbols, capped at the map size
    always_comb
    begin
        if (32'(num_ports_reg) > 32'(MAX_PORTS))
        begin
            np = NP_W'(MAX_PORTS);
        end
        else
        begin
            np = NP_W'(num_ports_reg);
        end
        if (32'(num_symbols_reg) > 32'(MAX_SYMBOLS))
        begin
            ns = NS_W'(MAX_SYMBOLS);
        end
        else
        begin
            ns = NS_W'(num_symbols_reg);
        end
    end

    assign total = TOT_W'(np) * TOT_W'(ns);

    // Range check and bit position of the incoming packet
    assign in_invalid = (32'(port_index) >= 32'(np)) || (32'(symbol_index) >= 32'(ns));
    assign idx_in     = IDX_W'(16'(port_index) * 16'(ns) + 16'(symbol_index));
    assign is_packet  = (command != sort_pkg::CMD_FLUSH);

    // Tag compare across all buckets: first match, else first free
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int b = 0; b < NUM_BUCKETS; b++)
        begin
            if (!match_found && busy_reg[b] && (bkt_slot_reg[b] == slot_id))
            begin
                match_found = 1'b1;
                match_idx   = BKT_W'(b);
            end
            if (!free_found && !busy_reg[b])
            begin
                free_found = 1'b1;
                free_idx   = BKT_W'(b);
            end
        end
    end

    // No match and no free bucket leaves bucket 0 selected
    assign sel        = match_found ? match_idx : (free_found ? free_idx : '0);
    assign claim_free = cmd.load && is_packet && !in_invalid && !match_found && free_found;

    // Item capture and bucket pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.load)
        begin
            ptr_reg <= is_packet ? sel : '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_slot_reg <= slot_id;
            idx_reg       <= idx_in;
        end
    end

    // Read-modify-write of the selected row
    assign cur_cnt   = bkt_cnt_reg[ptr_reg];
    assign cnt_inc   = cur_cnt + 1'b1;
    assign row_cur   = map_valid_reg[ptr_reg] ? rd_row_reg : '0;
    assign hit       = row_cur[idx_reg];
    assign row_wdata = row_cur | (MAP_BITS'(1) << idx_reg);
    assign complete  = (32'(cnt_inc) == 32'(total));
    assign write_bit = cmd.commit && !hit;

    // Flush age, modulo 2^32
    assign age = item_slot_reg - bkt_slot_reg[ptr_reg];

    // Busy and row-valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            map_valid_reg <= '0;
        end
        else
        begin
            if (claim_free)
            begin
                busy_reg[sel]      <= 1'b1;
                map_valid_reg[sel] <= 1'b0;
            end
            if (cmd.evict_claim)
            begin
                busy_reg[ptr_reg]      <= 1'b1;
                map_valid_reg[ptr_reg] <= 1'b0;
            end
            if (cmd.flush_clear)
            begin
                busy_reg[ptr_reg]      <= 1'b0;
                map_valid_reg[ptr_reg] <= 1'b0;
            end
            if (write_bit)
            begin
                if (complete)
                begin
                    busy_reg[ptr_reg]      <= 1'b0;
                    map_valid_reg[ptr_reg] <= 1'b0;
                end
                else
                begin
                    map_valid_reg[ptr_reg] <= 1'b1;
                end
            end
        end
    end

    // Bucket slot and count
    always_ff @(posedge clk)
    begin
        if (claim_free)
        begin
            bkt_slot_reg[sel] <= slot_id;
            bkt_cnt_reg[sel]  <= '0;
        end
        if (cmd.evict_claim)
        begin
            bkt_slot_reg[ptr_reg] <= item_slot_reg;
            bkt_cnt_reg[ptr_reg]  <= '0;
        end
        if (write_bit)
        begin
            bkt_cnt_reg[ptr_reg] <= complete ? '0 : cnt_inc;
        end
    end

    // Bitmap memory: read on accept, write on update
    always_ff @(posedge clk)
    begin
        if (write_bit)
        begin
            map_mem[ptr_reg] <= row_wdata;
        end
        if (cmd.load)
        begin
            rd_row_reg <= map_mem[sel];
        end
    end

    // Result contents
    always_comb
    begin
        case (cmd.kind)
            sort_pkg::EMIT_INVALID:
            begin
                emit_res  = sort_pkg::EV_DROP_INVALID;
                emit_slot = item_slot_reg;
                emit_cnt  = '0;
                emit_last = 1'b1;
            end
            sort_pkg::EMIT_EVICT:
            begin
                emit_res  = sort_pkg::EV_EVICT_FULL;
                emit_slot = bkt_slot_reg[ptr_reg];
                emit_cnt  = cur_cnt;
                emit_last = 1'b0;
            end
            sort_pkg::EMIT_STALE:
            begin
                emit_res  = sort_pkg::EV_EVICT_STALE;
                emit_slot = bkt_slot_reg[ptr_reg];
                emit_cnt  = cur_cnt;
                emit_last = 1'b0;
            end
            sort_pkg::EMIT_UPDATE:
            begin
                emit_slot = item_slot_reg;
                emit_last = 1'b1;
                if (hit)
                begin
                    emit_res = sort_pkg::EV_DROP_DUP;
                    emit_cnt = cur_cnt;
                end
                else if (complete)
                begin
                    emit_res = sort_pkg::EV_COMPLETE;
                    emit_cnt = cnt_inc;
                end
                else
                begin
                    emit_res = sort_pkg::EV_ACCEPTED;
                    emit_cnt = cnt_inc;
                end
            end
            default:
            begin
                emit_res  = sort_pkg::EV_FLUSH_DONE;
                emit_slot = item_slot_reg;
                emit_cnt  = '0;
                emit_last = 1'b1;
            end
        endcase
    end

    // Output register
    assign out_space = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_res_reg  <= emit_res;
            out_slot_reg <= emit_slot;
            out_cnt_reg  <= sort_pkg::CNT_OUT_W'(emit_cnt);
            out_last_reg <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_res_reg;
    assign event_slot    = out_slot_reg;
    assign arrived_count = out_cnt_reg;
    assign last          = out_last_reg;

    // Status to the controller
    assign stat.in_flush   = !is_packet;
    assign stat.in_invalid = in_invalid;
    assign stat.in_evict   = !match_found && !free_found;
    assign stat.stale      = busy_reg[ptr_reg] && (age > keepalive_reg);
    assign stat.ptr_last   = (ptr_reg == BKT_W'(NUM_BUCKETS - 1));
    assign stat.out_space  = out_space;

endmodule

FILE: hdl/slot_occasion_reassembly_tracker.sv
// A packet item is accepted in the idle state, which does the tag compare
// over all buckets and reads the bucket's bitmap row; the update state then
// sets the bit, bumps the count and loads the result. A packet that evicts
// bucket 0 passes the evict state first. A flush item walks the buckets with
// one shared age comparator, one per cycle unless a stale bucket waits for
// output space. Every result waits for room in the single output register,
// so a stalled consumer holds up the item. Bitmap rows are marked empty by
// per-bucket valid bits, so reset needs no clearing pass. Configuration
// writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
// slot_occasion_reassembly_tracker
// Per-slot packet reassembly table with duplicate drop, completion and
// stale bucket flush.
// ----------------------------------------------------------------------------
module slot_occasion_reassembly_tracker
#(
    parameter int NUM_BUCKETS = sort_pkg::DEF_NUM_BUCKETS,
    parameter int MAX_PORTS   = sort_pkg::DEF_MAX_PORTS,
    parameter int MAX_SYMBOLS = sort_pkg::DEF_MAX_SYMBOLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [sort_pkg::SLOT_W-1:0]     slot_id,
    input  logic [sort_pkg::SYM_W-1:0]      symbol_index,
    input  logic [sort_pkg::PORT_W-1:0]     port_index,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sort_pkg::RES_W-1:0]      event_res,
    output logic [sort_pkg::SLOT_W-1:0]     event_slot,
    output logic [sort_pkg::CNT_OUT_W-1:0]  arrived_count,
    output logic                            last,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sort_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sort_pkg::CFG_DATA_W-1:0] cfg_data
);

    sort_pkg::dp_cmd_t  cmd;
    sort_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    sort_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table and result path
    sort_dp
    #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .MAX_PORTS   (MAX_PORTS),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .slot_id       (slot_id),
        .symbol_index  (symbol_index),
        .port_index    (port_index),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .event_res     (event_res),
        .event_slot    (event_slot),
        .arrived_count (arrived_count),
        .last          (last)
    );

endmodule

FILE: hdl/sort_checker.sv
// ----------------------------------------------------------------------------
// sort_checker
// Port-level checks on the reassembly tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sort_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [sort_pkg::RES_W-1:0]     event_res,
    input logic [sort_pkg::SLOT_W-1:0]    event_slot,
    input logic [sort_pkg::CNT_OUT_W-1:0] arrived_count,
    input logic                           last
);

    localparam int PAYLOAD_W = sort_pkg::RES_W + sort_pkg::SLOT_W + sort_pkg::CNT_OUT_W + 1;

    logic                 is_evict;
    logic                 no_count;
    logic [PAYLOAD_W-1:0] out_payload;

    assign is_evict = (event_res == sort_pkg::EV_EVICT_FULL) ||
                      (event_res == sort_pkg::EV_EVICT_STALE);
    assign no_count = (event_res == sort_pkg::EV_DROP_INVALID) ||
                      (event_res == sort_pkg::EV_FLUSH_DONE);

    // all result fields side by side
    assign out_payload = {event_res, event_slot, arrived_count, last};

    // No result while reset is held
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid)

    // A stalled result holds its contents
    `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_payload))

    // Only evictions are followed by more results of the same item
    `ASSERT_RST(a_last_kind, clk, rst_n, out_valid |-> (!last == is_evict))

    // Nothing new is taken while an item still has results to come
    `ASSERT_RST(a_busy_mid_item, clk, rst_n, out_valid && !last |-> !in_ready)

    // Invalid drops and flush ends carry no count
    `ASSERT_RST(a_zero_count, clk, rst_n, out_valid && no_count |-> arrived_count == 0)

endmodule

bind slot_occasion_reassembly_tracker sort_checker u_sort_checker (.*);
